>>> hdl/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// shared widths, codes and types for the dense matrix multiply block
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_pkg;

  localparam int unsigned SIZE_DEF = 16;

  localparam int unsigned IDX_W  = 6;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned ACC_W  = 38;

  // input kind carried in tuser
  typedef enum logic {
    ACT_LOAD_B = 1'b0,
    ACT_A_ELEM = 1'b1
  } action_e;

  // broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic             mem_wr;
    logic             mem_rd;
    logic [IDX_W-1:0] mem_col;
    logic [IDX_W-1:0] mem_addr;
    logic [VAL_W-1:0] mem_wdata;
    logic [VAL_W-1:0] s1_value;
    logic             s1_v;
    logic             s2_v;
    logic             s2_first;
    logic             load;
    logic             shift;
  } dmm_ctl_t;

endpackage : dmm_pkg

`default_nettype wire

>>> hdl/dense_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top
// C = A x B on signed 16-bit elements with 38-bit sums that wrap, built as a
// row of SIZE multiply-accumulate cells, one per column of C
// ----------------------------------------------------------------------------
//  channel  dir  tdata (lsb first)                          tuser   tlast
//  s_axis   in   row[5:0] col[11:6] value[27:12] pad        action  -
//  m_axis   out  out_row[5:0] out_col[11:6] product[49:12]  -       last
//
//  an A or B element that does not close a row is never held off; A elements
//  of a row stream back to back through the read, multiply and accumulate
//  stages of every cell; the element closing a row waits until the result
//  chain has drained the previous row, and its first result shows once it has
//  passed the read and multiply stages and its sum is loaded into the chain
//  results leave one per cycle through the result chain, held under stall
//  reset clears control and the result chain only; B must be loaded before it is used
// ----------------------------------------------------------------------------
`default_nettype none

module dense_matrix_multiply_top
  import dmm_pkg::*;
#(
  parameter int unsigned SIZE = SIZE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // row, col, value, zero pad
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [55:0] m_axis_tdata,   // out_row, out_col, product, zero pad
  output logic             m_axis_tlast    // last
);

  localparam int unsigned CW = $clog2(SIZE + 1);
  localparam logic [IDX_W:0]   SIZE_X   = (IDX_W + 1)'(SIZE);
  localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(SIZE - 1);

  logic [IDX_W-1:0] in_row;
  logic [IDX_W-1:0] in_col;
  logic [VAL_W-1:0] in_value;
  action_e          in_action;
  logic             in_range;
  logic             in_closing;
  logic             in_xfer;
  logic             a_take;
  logic             out_xfer;

  logic             s1_v_q, s1_last_q, s1_first_q;
  logic [IDX_W-1:0] s1_row_q;
  logic [VAL_W-1:0] s1_value_q;
  logic             s2_v_q, s2_last_q, s2_first_q;
  logic [IDX_W-1:0] s2_row_q;

  logic [CW-1:0]    cnt_q;
  logic [IDX_W-1:0] out_col_q;
  logic [IDX_W-1:0] out_row_q;
  logic             load;

  dmm_ctl_t         ctl;
  logic [ACC_W-1:0] res_chain [SIZE+1];

  assign in_row    = s_axis_tdata[IDX_W-1:0];
  assign in_col    = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value  = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
  assign in_action = action_e'(s_axis_tuser);

  assign in_range   = ({1'b0, in_row} < SIZE_X) && ({1'b0, in_col} < SIZE_X);
  assign in_closing = (in_action == ACT_A_ELEM) && in_range && (in_col == LAST_COL);

  // a closing element must not load the chain before it is empty
  assign s_axis_tready = !in_closing || ((cnt_q == '0) && !s1_last_q && !s2_last_q);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign a_take        = in_xfer && in_range && (in_action == ACT_A_ELEM);

  assign load     = s2_v_q && s2_last_q;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_first_q <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_last_q  <= 1'b0;
      s2_first_q <= 1'b0;
      cnt_q      <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
    end else begin
      s1_v_q     <= a_take;
      s1_last_q  <= a_take && (in_col == LAST_COL);
      s1_first_q <= in_col == '0;
      s2_v_q     <= s1_v_q;
      s2_last_q  <= s1_last_q;
      s2_first_q <= s1_first_q;
      if (load) begin
        cnt_q     <= CW'(SIZE);
        out_col_q <= '0;
        out_row_q <= s2_row_q;
      end else if (out_xfer) begin
        cnt_q     <= cnt_q - 1'b1;
        out_col_q <= out_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      s1_row_q   <= in_row;
      s1_value_q <= in_value;
    end
    s2_row_q <= s1_row_q;
  end

  always_comb begin
    ctl           = '0;
    ctl.mem_wr    = in_xfer && in_range && (in_action == ACT_LOAD_B);
    ctl.mem_rd    = a_take;
    ctl.mem_col   = in_col;
    ctl.mem_addr  = (in_action == ACT_LOAD_B) ? in_row : in_col;
    ctl.mem_wdata = in_value;
    ctl.s1_value  = s1_value_q;
    ctl.s1_v      = s1_v_q;
    ctl.s2_v      = s2_v_q;
    ctl.s2_first  = s2_first_q;
    ctl.load      = load;
    ctl.shift     = out_xfer;
  end

  assign res_chain[SIZE] = '0;

  for (genvar j = 0; j < SIZE; j++) begin : g_cell
    dmm_cell #(
      .SIZE (SIZE),
      .IDX  (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .res_i  (res_chain[j+1]),
      .res_o  (res_chain[j])
    );
  end

  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tlast  = out_col_q == LAST_COL;
  assign m_axis_tdata  = {6'b0, res_chain[0], out_col_q, out_row_q};

  a_load_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (cnt_q == '0))
    else $error("result chain loaded while still draining");

  a_last_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (cnt_q == CW'(1))))
    else $error("tlast out of step with drain count");

  a_load_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (m_axis_tvalid && (out_col_q == '0)))
    else $error("row drain did not start at column zero");

  a_close_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_last_q |-> !s1_last_q)
    else $error("two closing elements in flight");

endmodule : dense_matrix_multiply_top

`default_nettype wire

>>> hdl/dmm_ram.sv
// ----------------------------------------------------------------------------
// dmm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : dmm_ram

`default_nettype wire

>>> hdl/dmm_cell.sv
// ----------------------------------------------------------------------------
// dmm_cell
// one column of C: holds column IDX of B, multiplies, accumulates, and
// forms one stage of the result shift chain toward column 0
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_cell
  import dmm_pkg::*;
#(
  parameter int unsigned SIZE = SIZE_DEF,
  parameter int unsigned IDX  = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dmm_ctl_t         ctl_i,
  input  wire logic [ACC_W-1:0] res_i,
  output logic      [ACC_W-1:0] res_o
);

  localparam int unsigned AW = $clog2(SIZE);

  logic                     wr_sel;
  logic [VAL_W-1:0]         b_rdata;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic [ACC_W-1:0]         res_q;

  assign wr_sel = ctl_i.mem_wr && (ctl_i.mem_col == IDX_W'(IDX));

  // entry k of this column is B[k][IDX]
  dmm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SIZE)
  ) u_bcol (
    .clk_i   (clk_i),
    .we_i    (wr_sel),
    .waddr_i (ctl_i.mem_addr[AW-1:0]),
    .wdata_i (ctl_i.mem_wdata),
    .re_i    (ctl_i.mem_rd),
    .raddr_i (ctl_i.mem_addr[AW-1:0]),
    .rdata_o (b_rdata)
  );

  assign prod_x = ACC_W'(prod_q);
  assign acc_d  = ctl_i.s2_first ? prod_x : (acc_q + prod_x);

  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_v) begin
      prod_q <= $signed(ctl_i.s1_value) * $signed(b_rdata);
    end
    if (ctl_i.s2_v) begin
      acc_q <= acc_d;
    end
  end

  // result chain: capture the finished sum, then hand it toward column 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (ctl_i.load) begin
      res_q <= acc_d;
    end else if (ctl_i.shift) begin
      res_q <= res_i;
    end
  end

  assign res_o = res_q;

endmodule : dmm_cell

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// loads B, streams rows of A into dense_matrix_multiply_top and checks each
// C element against a shadow of the B store and the row accumulators
// ----------------------------------------------------------------------------
module testbench;
  import dmm_pkg::*;

  localparam int unsigned SIZE        = SIZE_DEF;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned DIR_N       = 24;
  localparam int unsigned RAND_ITEMS  = 410;
  localparam int unsigned CALM_AFTER  = 330;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    action_e          act;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } elem_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] prod;
    logic             last;
  } c_elem_t;

  typedef struct packed {
    elem_t            el;
    logic             typed;
    logic [ACC_W-1:0] prod;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;    // row, col, value, zero pad
  logic        s_axis_tuser  = 1'b0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;          // out_row, out_col, product, zero pad
  logic        m_axis_tlast;

  logic signed [VAL_W-1:0] b_shadow [SIZE][SIZE];
  logic [ACC_W-1:0]        acc_shadow [SIZE];
  c_elem_t                 c_expect_q [$];
  int unsigned             mismatch_cnt = 0;
  int unsigned             taken_cnt    = 0;
  int unsigned             cycle_cnt    = 0;
  bit                      calm         = 1'b0;

  // B is all most-negative until the table's last loads, so the typed closing rows read off easily
  dir_row_t dir_tab [DIR_N] = '{
    '{'{ACT_A_ELEM, 6'd0,  6'd0,  16'h8000}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd0,  6'd15, 16'h8000}, 1'b1, 38'd2147483648},
    '{'{ACT_A_ELEM, 6'd15, 6'd0,  16'h7FFF}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd15, 6'd15, 16'h8000}, 1'b1, 38'd32768},
    '{'{ACT_A_ELEM, 6'd5,  6'd0,  16'h7FFF}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd5,  6'd15, 16'h7FFF}, 1'b1, -38'sd2147418112},
    '{'{ACT_A_ELEM, 6'd63, 6'd0,  16'h0001}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd0,  6'd63, 16'hFFFF}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd16, 6'd15, 16'h0005}, 1'b0, '0},
    '{'{ACT_LOAD_B, 6'd63, 6'd63, 16'h0005}, 1'b0, '0},
    '{'{ACT_LOAD_B, 6'd16, 6'd0,  16'hFFFF}, 1'b0, '0},
    '{'{ACT_LOAD_B, 6'd0,  6'd16, 16'h0007}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd1,  6'd0,  16'h0000}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd1,  6'd15, 16'h0000}, 1'b1, 38'd0},
    // repeated column 0 clears again
    '{'{ACT_A_ELEM, 6'd2,  6'd0,  16'hFFFF}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd2,  6'd0,  16'hFFFF}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd2,  6'd15, 16'h0001}, 1'b1, 38'd0},
    // no column 0: builds on the previous row's sums
    '{'{ACT_A_ELEM, 6'd3,  6'd15, 16'h8000}, 1'b1, 38'd1073741824},
    '{'{ACT_LOAD_B, 6'd0,  6'd0,  16'h7FFF}, 1'b0, '0},
    '{'{ACT_LOAD_B, 6'd15, 6'd15, 16'h0000}, 1'b0, '0},
    '{'{ACT_LOAD_B, 6'd7,  6'd3,  16'hFFFF}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd4,  6'd0,  16'h8000}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd4,  6'd7,  16'h3039}, 1'b0, '0},
    '{'{ACT_A_ELEM, 6'd4,  6'd15, 16'h7FFF}, 1'b0, '0}
  };

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  dense_matrix_multiply_top #(
    .SIZE(SIZE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic elem_t make_element(action_e a, int unsigned r, int unsigned c, int v);
    elem_t el;
    el.act   = a;
    el.row   = IDX_W'(r);
    el.col   = IDX_W'(c);
    el.value = VAL_W'(v);
    return el;
  endfunction

  function automatic int rand_value();
    case ($urandom_range(0, 15))
      0, 1: return -32768;
      2, 3: return 32767;
      4: return 0;
      5: return -1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // something the block must ignore: row or column past the matrix
  function automatic elem_t stray_element();
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    r = IDX_W'($urandom_range(0, 63));
    c = IDX_W'($urandom_range(0, 63));
    if (r < SIZE && c < SIZE) begin
      if ($urandom_range(0, 1)) begin
        r = r | IDX_W'(SIZE << $urandom_range(0, 1));
      end else begin
        c = c | IDX_W'(SIZE << $urandom_range(0, 1));
      end
    end
    return make_element(action_e'($urandom_range(0, 1)), r, c, $urandom);
  endfunction

  // shadow of the B store and the row sums, queues the C row on column SIZE-1
  function automatic void predict_c_row(elem_t el, logic typed, logic [ACC_W-1:0] typed_prod);
    logic signed [PROD_W-1:0] p;
    c_elem_t c;
    if (el.row >= SIZE || el.col >= SIZE) return;
    if (el.act == ACT_LOAD_B) begin
      b_shadow[el.row][el.col] = el.value;
      return;
    end
    if (el.col == 0) begin
      foreach (acc_shadow[j]) acc_shadow[j] = '0;
    end
    for (int j = 0; j < SIZE; j++) begin
      p = $signed(el.value) * b_shadow[el.col][j];
      acc_shadow[j] = acc_shadow[j] + {{(ACC_W - PROD_W){p[PROD_W-1]}}, p};
    end
    if (el.col != SIZE - 1) return;
    for (int j = 0; j < SIZE; j++) begin
      c.row  = el.row;
      c.col  = IDX_W'(j);
      c.prod = typed ? typed_prod : acc_shadow[j];
      c.last = (j == SIZE - 1);
      c_expect_q.push_back(c);
    end
  endfunction

  task automatic put_element(elem_t el, logic typed = 1'b0, logic [ACC_W-1:0] typed_prod = '0);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, el.value, el.col, el.row};
    s_axis_tuser  <= el.act;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_c_row(el, typed, typed_prod);
    if (el.row < SIZE && el.col < SIZE) taken_cnt++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (c_expect_q.size() != 0);
  endtask

  task automatic send_a_row(int unsigned r);
    for (int k = 0; k < SIZE; k++) put_element(make_element(ACT_A_ELEM, r, k, rand_value()));
  endtask

  task automatic send_b_row(int unsigned r);
    for (int k = 0; k < SIZE; k++) put_element(make_element(ACT_LOAD_B, r, k, rand_value()));
  endtask

  // columns skipped and repeated, sometimes closed with column SIZE-1
  task automatic send_a_scramble(int unsigned r);
    repeat ($urandom_range(1, 20)) begin
      put_element(make_element(ACT_A_ELEM, r, $urandom_range(0, SIZE - 1), rand_value()));
    end
    if ($urandom_range(0, 1)) put_element(make_element(ACT_A_ELEM, r, SIZE - 1, rand_value()));
  endtask

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 40)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    c_elem_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (c_expect_q.size() == 0) begin
        report_mismatch("unexpected transfer", '0, m_axis_tdata);
      end else begin
        want = c_expect_q.pop_front();
        if (m_axis_tdata[5:0] != want.row) report_mismatch("out_row", want.row, m_axis_tdata[5:0]);
        if (m_axis_tdata[11:6] != want.col) report_mismatch("out_col", want.col, m_axis_tdata[11:6]);
        if (m_axis_tdata[49:12] != want.prod) begin
          report_mismatch("product", want.prod, m_axis_tdata[49:12]);
        end
        if (m_axis_tdata[55:50] != '0) report_mismatch("pad", '0, m_axis_tdata[55:50]);
        if (m_axis_tlast != want.last) report_mismatch("last", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dense_matrix_multiply_top test failed");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < SIZE; r++) begin
      for (int c = 0; c < SIZE; c++) put_element(make_element(ACT_LOAD_B, r, c, -32768));
    end
    foreach (dir_tab[i]) put_element(dir_tab[i].el, dir_tab[i].typed, dir_tab[i].prod);
    wait_drained();
    taken_cnt = 0;

    // long run on one column with B row 1 still most-negative: sums wrap past 2^37
    put_element(make_element(ACT_A_ELEM, 9, 0, -32768));
    repeat (139) put_element(make_element(ACT_A_ELEM, 9, 1, -32768));
    put_element(make_element(ACT_A_ELEM, 9, SIZE - 1, rand_value()));
    wait_drained();

    while (taken_cnt < RAND_ITEMS) begin
      if (taken_cnt >= CALM_AFTER) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_a_row($urandom_range(0, SIZE - 1));
      end else if (pick < 62) begin
        send_b_row($urandom_range(0, SIZE - 1));
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 4)) begin
          put_element(make_element(ACT_LOAD_B, $urandom_range(0, SIZE - 1),
                                   $urandom_range(0, SIZE - 1), rand_value()));
        end
      end else if (pick < 87) begin
        send_a_scramble($urandom_range(0, SIZE - 1));
      end else begin
        repeat ($urandom_range(1, 3)) put_element(stray_element());
      end
      if (!calm && $urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (4 * SIZE) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("dense_matrix_multiply_top test passed");
    end else begin
      $display("dense_matrix_multiply_top test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/dmm_pkg.sv
hdl/dmm_ram.sv
hdl/dmm_cell.sv
hdl/dense_matrix_multiply_top.sv
tb/sv/testbench.sv
